// File: rtl/core/akd_pkg.sv
// ----------------------------------------------------------------------------
// akd_pkg
// Shared types, codes and helpers for the analog keypad debouncer.
// ----------------------------------------------------------------------------
package akd_pkg;

   // ADC sample bits taken from the request field
   localparam int SAMPLE_BITS = 16;
   localparam int REG_BITS    = 16;
   localparam int NUM_REGS    = 6;
   localparam int INDEX_BITS  = $clog2(NUM_REGS);

   localparam logic [REG_BITS-1:0] COUNT_MAX = {REG_BITS{1'b1}};

   typedef enum logic [2:0] {
      KEY_NONE  = 3'd0,
      KEY_LEFT  = 3'd1,
      KEY_UP    = 3'd2,
      KEY_DOWN  = 3'd3,
      KEY_RIGHT = 3'd4,
      KEY_ENTER = 3'd5
   } key_type;

   typedef enum logic [1:0] {
      CMD_SAMPLE = 2'd0,
      CMD_TICK   = 2'd1,
      CMD_POLL   = 2'd2
   } cmd_type;

   typedef enum logic [INDEX_BITS-1:0] {
      REG_THRESH_LEFT    = 3'd0,
      REG_THRESH_UP      = 3'd1,
      REG_THRESH_DOWN    = 3'd2,
      REG_THRESH_RIGHT   = 3'd3,
      REG_THRESH_ENTER   = 3'd4,
      REG_DEBOUNCE_TICKS = 3'd5
   } reg_index_type;

   localparam logic [REG_BITS-1:0] RST_THRESH_LEFT    = 16'd70;
   localparam logic [REG_BITS-1:0] RST_THRESH_UP      = 16'd230;
   localparam logic [REG_BITS-1:0] RST_THRESH_DOWN    = 16'd410;
   localparam logic [REG_BITS-1:0] RST_THRESH_RIGHT   = 16'd620;
   localparam logic [REG_BITS-1:0] RST_THRESH_ENTER   = 16'd880;
   localparam logic [REG_BITS-1:0] RST_DEBOUNCE_TICKS = 16'd100;

   // Configuration seen by the datapath
   typedef struct packed {
      logic [REG_BITS-1:0] thresh_left;
      logic [REG_BITS-1:0] thresh_up;
      logic [REG_BITS-1:0] thresh_down;
      logic [REG_BITS-1:0] thresh_right;
      logic [REG_BITS-1:0] thresh_enter;
      logic [REG_BITS-1:0] debounce_ticks;
   } cfg_type;

   // Map a sample to a raw key; the first threshold that holds wins
   function automatic key_type classify(input logic [REG_BITS-1:0] v,
                                        input cfg_type cfg);
      key_type k;
      if (v < cfg.thresh_left) begin
         k = KEY_LEFT;
      end else if (v < cfg.thresh_up) begin
         k = KEY_UP;
      end else if (v < cfg.thresh_down) begin
         k = KEY_DOWN;
      end else if (v < cfg.thresh_right) begin
         k = KEY_RIGHT;
      end else if (v < cfg.thresh_enter) begin
         k = KEY_ENTER;
      end else begin
         k = KEY_NONE;
      end
      return k;
   endfunction

endpackage

// File: rtl/core/akd_ifs.sv
// ----------------------------------------------------------------------------
// akd_ifs
// Valid/ready channels for keypad requests and debounced-key responses.
// ----------------------------------------------------------------------------
interface akd_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  cmd;
   logic [15:0] sample_value;

   modport source (output valid, output cmd, output sample_value, input ready);
   modport sink   (input valid, input cmd, input sample_value, output ready);
endinterface

interface akd_rsp_if;
   logic       valid;
   logic       ready;
   logic [2:0] settled_key;
   logic       pressed_valid;
   logic [2:0] pressed_key;

   modport source (output valid, output settled_key, output pressed_valid,
                   output pressed_key, input ready);
   modport sink   (input valid, input settled_key, input pressed_valid,
                   input pressed_key, output ready);
endinterface

// File: rtl/core/analog_keypad_debouncer_top.sv
// ----------------------------------------------------------------------------
// analog_keypad_debouncer_top
// Resistor-ladder keypad decoder with tick-based debounce and press events.
// ----------------------------------------------------------------------------
// The block takes one request per clock unless a poll is held: a sample
// request classifies an ADC reading into a raw key, a tick request advances
// the saturating stability counter, and a poll request returns one response
// with the debounced key and a pressed event. A request lands in an input
// register and is resolved from there by the compare and counter logic; a
// poll's response is then held in the output register. Sample and tick
// requests never wait; a poll waits in the input register only while the
// previous response sits untaken in the output register, which is what sets
// the throughput.
// Thresholds are 16-bit ADC counts whose reset values suit a 10-bit converter.
module analog_keypad_debouncer_top (
   input  logic                          clock,
   input  logic                          reset,
   akd_req_if.sink                       req_chan,
   akd_rsp_if.source                     rsp_chan,
   input  logic                          csr_wr_en,
   input  logic [akd_pkg::INDEX_BITS-1:0] csr_index,
   input  logic [akd_pkg::REG_BITS-1:0]  csr_wdata
);
   import akd_pkg::*;

   cfg_type cfg;

   akd_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // Input register
   logic                 s1_valid_ff, s1_valid_in;
   logic [1:0]           s1_cmd_ff;
   logic [REG_BITS-1:0]  s1_sample_ff;

   // Keypad state
   key_type              raw_key_ff, raw_key_in;
   logic [REG_BITS-1:0]  stable_count_ff, stable_count_in;
   key_type              prev_deb_ff, prev_deb_in;

   // Output register
   logic                 rsp_valid_ff, rsp_valid_in;
   key_type              rsp_deb_ff, rsp_deb_in;
   logic                 rsp_pv_ff, rsp_pv_in;
   key_type              rsp_pk_ff, rsp_pk_in;

   logic                 out_free;
   logic                 s1_go;
   logic                 req_take;
   key_type              deb_key;
   logic                 pressed;

   // Handshake: polls need room in the output register
   assign out_free = !rsp_valid_ff || rsp_chan.ready;
   assign s1_go    = s1_valid_ff &&
                     ((cmd_type'(s1_cmd_ff) != CMD_POLL) || out_free);
   assign req_chan.ready = !s1_valid_ff || s1_go;
   assign req_take = req_chan.valid && req_chan.ready;

   assign s1_valid_in = req_take || (s1_valid_ff && !s1_go);

   // Debounced key and press event from current state
   assign deb_key = (stable_count_ff > cfg.debounce_ticks) ? raw_key_ff : KEY_NONE;
   assign pressed = (prev_deb_ff != KEY_NONE) && (prev_deb_ff != deb_key);

   // Resolve the held request
   always_comb begin
      raw_key_in      = raw_key_ff;
      stable_count_in = stable_count_ff;
      prev_deb_in     = prev_deb_ff;
      rsp_deb_in      = rsp_deb_ff;
      rsp_pv_in       = rsp_pv_ff;
      rsp_pk_in       = rsp_pk_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_chan.ready;
      if (s1_go) begin
         case (cmd_type'(s1_cmd_ff))
            CMD_SAMPLE: begin
               raw_key_in = classify(s1_sample_ff, cfg);
               if (raw_key_in != raw_key_ff) begin
                  stable_count_in = '0;
               end
            end
            CMD_TICK: begin
               if (stable_count_ff != COUNT_MAX) begin
                  stable_count_in = stable_count_ff + 1'b1;
               end
            end
            CMD_POLL: begin
               rsp_valid_in = 1'b1;
               rsp_deb_in   = deb_key;
               rsp_pv_in    = pressed;
               rsp_pk_in    = pressed ? prev_deb_ff : KEY_NONE;
               prev_deb_in  = deb_key;
            end
            default: begin
               raw_key_in = raw_key_ff;
            end
         endcase
      end
   end

   // Control and state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff     <= 1'b0;
         rsp_valid_ff    <= 1'b0;
         raw_key_ff      <= KEY_NONE;
         stable_count_ff <= COUNT_MAX;
         prev_deb_ff     <= KEY_NONE;
      end else begin
         s1_valid_ff     <= s1_valid_in;
         rsp_valid_ff    <= rsp_valid_in;
         raw_key_ff      <= raw_key_in;
         stable_count_ff <= stable_count_in;
         prev_deb_ff     <= prev_deb_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_cmd_ff    <= req_chan.cmd;
         s1_sample_ff <= {{(REG_BITS-SAMPLE_BITS){1'b0}},
                          req_chan.sample_value[SAMPLE_BITS-1:0]};
      end
      rsp_deb_ff <= rsp_deb_in;
      rsp_pv_ff  <= rsp_pv_in;
      rsp_pk_ff  <= rsp_pk_in;
   end

   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.settled_key   = rsp_deb_ff;
   assign rsp_chan.pressed_valid = rsp_pv_ff;
   assign rsp_chan.pressed_key   = rsp_pk_ff;

`ifndef ASSERT_OFF
   // A press event never carries none and always names a changed key
   a_press_key: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_pv_ff |-> (rsp_pk_ff != KEY_NONE) && (rsp_pk_ff != rsp_deb_ff))
      else $error("press event key is none or unchanged");

   // Without a press event the event key reads zero
   a_no_press_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_pv_ff |-> rsp_pk_ff == KEY_NONE)
      else $error("press key set without press event");

   // A tick below saturation advances the counter by one
   a_tick_step: assert property (@(posedge clock) disable iff (reset)
      s1_go && (cmd_type'(s1_cmd_ff) == CMD_TICK) && (stable_count_ff != COUNT_MAX)
      |=> stable_count_ff == $past(stable_count_ff) + 1'b1)
      else $error("tick did not advance counter");

   // The debounced key reported becomes the remembered key
   a_prev_track: assert property (@(posedge clock) disable iff (reset)
      s1_go && (cmd_type'(s1_cmd_ff) == CMD_POLL) |=> prev_deb_ff == rsp_deb_ff)
      else $error("remembered key does not match response");
`endif

endmodule

// File: rtl/core/akd_csr.sv
// ----------------------------------------------------------------------------
// akd_csr
// Threshold and debounce-limit registers behind the plain write port.
// ----------------------------------------------------------------------------
module akd_csr (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_wr_en,
   input  logic [akd_pkg::INDEX_BITS-1:0] csr_index,
   input  logic [akd_pkg::REG_BITS-1:0]  csr_wdata,
   output akd_pkg::cfg_type              cfg
);
   import akd_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   // Decode the write; out-of-range indexes drop
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         case (reg_index_type'(csr_index))
            REG_THRESH_LEFT:    cfg_in.thresh_left    = csr_wdata;
            REG_THRESH_UP:      cfg_in.thresh_up      = csr_wdata;
            REG_THRESH_DOWN:    cfg_in.thresh_down    = csr_wdata;
            REG_THRESH_RIGHT:   cfg_in.thresh_right   = csr_wdata;
            REG_THRESH_ENTER:   cfg_in.thresh_enter   = csr_wdata;
            REG_DEBOUNCE_TICKS: cfg_in.debounce_ticks = csr_wdata;
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.thresh_left    <= RST_THRESH_LEFT;
         cfg_ff.thresh_up      <= RST_THRESH_UP;
         cfg_ff.thresh_down    <= RST_THRESH_DOWN;
         cfg_ff.thresh_right   <= RST_THRESH_RIGHT;
         cfg_ff.thresh_enter   <= RST_THRESH_ENTER;
         cfg_ff.debounce_ticks <= RST_DEBOUNCE_TICKS;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// File: dv/akd_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// akd_checker
// Watches the keypad request, response and register-write ports, keeps its
// own model of the raw key, stability counter and last debounced key, and
// compares every poll response against the oldest predicted report.
// ----------------------------------------------------------------------------
module akd_checker (
   input  logic                           clock,
   input  logic                           reset,
   akd_req_if                             req_mon,
   akd_rsp_if                             rsp_mon,
   input  logic                           csr_wr_en,
   input  logic [akd_pkg::INDEX_BITS-1:0] csr_index,
   input  logic [akd_pkg::REG_BITS-1:0]   csr_wdata,
   output int                             fail_count,
   output int                             pending_count
);
   import akd_pkg::*;

   typedef struct packed {
      key_type settled_key;
      logic    pressed_valid;
      key_type pressed_key;
   } key_report_type;

   // Shadow registers and keypad state
   cfg_type             cfg_shadow;
   key_type             raw_key_q;
   logic [REG_BITS-1:0] stable_ticks;
   key_type             last_debounced;
   key_report_type      expected_reports[$];
   int                  mismatch_total = 0;

   // Walk the thresholds in ladder order; the first one above the sample wins
   function automatic key_type decode_sample(input logic [15:0] value);
      logic [REG_BITS-1:0] ladder [5];
      logic [REG_BITS-1:0] reading;
      key_type             found;
      ladder[0] = cfg_shadow.thresh_left;
      ladder[1] = cfg_shadow.thresh_up;
      ladder[2] = cfg_shadow.thresh_down;
      ladder[3] = cfg_shadow.thresh_right;
      ladder[4] = cfg_shadow.thresh_enter;
      reading = '0;
      reading[SAMPLE_BITS-1:0] = value[SAMPLE_BITS-1:0];
      found = KEY_NONE;
      for (int i = 4; i >= 0; i--) begin
         if (reading < ladder[i]) begin
            found = key_type'(i + 1);
         end
      end
      return found;
   endfunction

   // Resolve a poll and advance the last debounced key
   function automatic key_report_type poll_outcome();
      key_report_type rep;
      key_type        settled;
      settled = (stable_ticks > cfg_shadow.debounce_ticks) ? raw_key_q : KEY_NONE;
      rep.settled_key   = settled;
      rep.pressed_valid = (last_debounced != KEY_NONE) && (last_debounced != settled);
      rep.pressed_key   = rep.pressed_valid ? last_debounced : KEY_NONE;
      last_debounced    = settled;
      return rep;
   endfunction

   always @(posedge clock) begin : monitor
      key_report_type want;
      key_type        fresh;
      if (reset) begin
         cfg_shadow.thresh_left    = RST_THRESH_LEFT;
         cfg_shadow.thresh_up      = RST_THRESH_UP;
         cfg_shadow.thresh_down    = RST_THRESH_DOWN;
         cfg_shadow.thresh_right   = RST_THRESH_RIGHT;
         cfg_shadow.thresh_enter   = RST_THRESH_ENTER;
         cfg_shadow.debounce_ticks = RST_DEBOUNCE_TICKS;
         raw_key_q      = KEY_NONE;
         stable_ticks   = COUNT_MAX;
         last_debounced = KEY_NONE;
         expected_reports.delete();
      end else begin
         // Compare a taken response with the oldest prediction
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (expected_reports.size() == 0) begin
               $error("response with nothing expected: settled_key %0d",
                      rsp_mon.settled_key);
               mismatch_total++;
            end else begin
               want = expected_reports.pop_front();
               if (rsp_mon.settled_key !== want.settled_key) begin
                  $error("settled_key: expected %0d, actual %0d",
                         want.settled_key, rsp_mon.settled_key);
                  mismatch_total++;
               end
               if (rsp_mon.pressed_valid !== want.pressed_valid) begin
                  $error("pressed_valid: expected %0d, actual %0d",
                         want.pressed_valid, rsp_mon.pressed_valid);
                  mismatch_total++;
               end
               if (rsp_mon.pressed_key !== want.pressed_key) begin
                  $error("pressed_key: expected %0d, actual %0d",
                         want.pressed_key, rsp_mon.pressed_key);
                  mismatch_total++;
               end
            end
         end

         // Track register writes; spare indexes are dropped
         if (csr_wr_en) begin
            case (csr_index)
               REG_THRESH_LEFT:    cfg_shadow.thresh_left    = csr_wdata;
               REG_THRESH_UP:      cfg_shadow.thresh_up      = csr_wdata;
               REG_THRESH_DOWN:    cfg_shadow.thresh_down    = csr_wdata;
               REG_THRESH_RIGHT:   cfg_shadow.thresh_right   = csr_wdata;
               REG_THRESH_ENTER:   cfg_shadow.thresh_enter   = csr_wdata;
               REG_DEBOUNCE_TICKS: cfg_shadow.debounce_ticks = csr_wdata;
               default: ;
            endcase
         end

         // Apply an accepted request
         if (req_mon.valid && req_mon.ready) begin
            case (req_mon.cmd)
               CMD_SAMPLE: begin
                  fresh = decode_sample(req_mon.sample_value);
                  if (fresh != raw_key_q) begin
                     stable_ticks = '0;
                  end
                  raw_key_q = fresh;
               end
               CMD_TICK: begin
                  if (stable_ticks != COUNT_MAX) begin
                     stable_ticks = stable_ticks + 1'b1;
                  end
               end
               CMD_POLL: begin
                  expected_reports.push_back(poll_outcome());
               end
               default: ;
            endcase
         end
      end
      fail_count    <= mismatch_total;
      pending_count <= expected_reports.size();
   end

endmodule

// File: dv/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Drives the keypad debouncer with directed and random sample, tick and poll
// requests across several threshold settings, with random gaps and stalls.
// ----------------------------------------------------------------------------
module tb_top;
   import akd_pkg::*;

   localparam int CYCLE_LIMIT     = 1_000_000;
   localparam int SETTLE_CYCLES   = 4;
   localparam int TAIL_CYCLES     = 8;
   localparam int ITEMS_PER_PHASE = 72;

   localparam logic [INDEX_BITS-1:0] REG_SPARE_A = 3'd6;
   localparam logic [INDEX_BITS-1:0] REG_SPARE_B = 3'd7;
   localparam logic [1:0]            CMD_UNUSED  = 2'd3;

   logic                  clock;
   logic                  reset;
   logic                  csr_wr_en;
   logic [INDEX_BITS-1:0] csr_index;
   logic [REG_BITS-1:0]   csr_wdata;
   int                    fail_count;
   int                    pending_count;
   int                    cycle_count = 0;
   bit                    quiet = 1'b0;

   // Thresholds and debounce limit currently loaded, used to aim samples
   logic [REG_BITS-1:0]   thr_now [5];
   logic [REG_BITS-1:0]   ticks_limit;

   akd_req_if req_chan ();
   akd_rsp_if rsp_chan ();

   analog_keypad_debouncer_top u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   akd_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_mon       (req_chan),
      .rsp_mon       (rsp_chan),
      .csr_wr_en     (csr_wr_en),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .fail_count    (fail_count),
      .pending_count (pending_count)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Stop a hung run
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("status: fail");
      $finish;
   end

   // Response side: stall at random except in quiet stretches
   initial begin
      rsp_chan.ready <= 1'b0;
      forever begin
         @(negedge clock);
         rsp_chan.ready <= quiet || ($urandom_range(0, 99) >= 30);
      end
   end

   // Present one request, maybe after a gap, and hold it until accepted
   task automatic send_request(input logic [1:0] cmd, input logic [15:0] value);
      int gap;
      gap = 0;
      if (!quiet && $urandom_range(0, 99) < 30) begin
         gap = $urandom_range(1, 4);
      end
      @(negedge clock);
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_chan.valid        <= 1'b1;
      req_chan.cmd          <= cmd;
      req_chan.sample_value <= value;
      do @(posedge clock); while (!req_chan.ready);
   endtask

   // Drop valid and wait until every poll has been answered
   task automatic drain_requests();
      @(negedge clock);
      req_chan.valid <= 1'b0;
      while (pending_count != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [INDEX_BITS-1:0] idx,
                            input logic [REG_BITS-1:0] data);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
   endtask

   // Load a full register set while idle, plus writes to the spare indexes
   task automatic load_config(input logic [REG_BITS-1:0] t_left,
                              input logic [REG_BITS-1:0] t_up,
                              input logic [REG_BITS-1:0] t_down,
                              input logic [REG_BITS-1:0] t_right,
                              input logic [REG_BITS-1:0] t_enter,
                              input logic [REG_BITS-1:0] limit);
      drain_requests();
      write_reg(REG_SPARE_A, 16'($urandom_range(0, 65535)));
      write_reg(REG_THRESH_LEFT, t_left);
      write_reg(REG_THRESH_UP, t_up);
      write_reg(REG_THRESH_DOWN, t_down);
      write_reg(REG_THRESH_RIGHT, t_right);
      write_reg(REG_THRESH_ENTER, t_enter);
      write_reg(REG_DEBOUNCE_TICKS, limit);
      write_reg(REG_SPARE_B, 16'($urandom_range(0, 65535)));
      @(negedge clock);
      csr_wr_en <= 1'b0;
      thr_now[0]  = t_left;
      thr_now[1]  = t_up;
      thr_now[2]  = t_down;
      thr_now[3]  = t_right;
      thr_now[4]  = t_enter;
      ticks_limit = limit;
   endtask

   task automatic load_sorted(input logic [REG_BITS-1:0] limit);
      logic [REG_BITS-1:0] ladder[$];
      repeat (5) ladder.push_back(16'($urandom_range(0, 65535)));
      ladder.sort();
      load_config(ladder[0], ladder[1], ladder[2], ladder[3], ladder[4], limit);
   endtask

   // Aim a sample at a threshold edge, an extreme, or anywhere
   function automatic logic [15:0] pick_sample();
      int pick;
      pick = $urandom_range(0, 9);
      if (pick < 4) begin
         return 16'($urandom_range(0, 65535));
      end else if (pick == 4) begin
         return ($urandom_range(0, 1) != 0) ? 16'hFFFF : 16'h0000;
      end
      return thr_now[$urandom_range(0, 4)] + 16'($urandom_range(0, 3)) - 16'd2;
   endfunction

   // Mostly press sequences (settle, tick, poll), the rest loose requests
   task automatic run_random_phase(input int target);
      int          done;
      int          bounces;
      int          span;
      logic [15:0] held;
      done = 0;
      while (done < target) begin
         if ($urandom_range(0, 99) < 70) begin
            held    = pick_sample();
            bounces = $urandom_range(0, 2);
            repeat (bounces) begin
               send_request(CMD_SAMPLE, pick_sample());
               done++;
            end
            send_request(CMD_SAMPLE, held);
            done++;
            span = (ticks_limit < 8) ? $urandom_range(0, ticks_limit + 3)
                                     : $urandom_range(0, 10);
            repeat (span) begin
               send_request(CMD_TICK, 16'($urandom_range(0, 65535)));
               done++;
            end
            send_request(CMD_POLL, 16'($urandom_range(0, 65535)));
            done++;
         end else begin
            case ($urandom_range(0, 3))
               0: begin
                  send_request(CMD_SAMPLE, pick_sample());
                  done++;
               end
               1: begin
                  send_request(CMD_TICK, 16'($urandom_range(0, 65535)));
                  done++;
               end
               2: begin
                  send_request(CMD_POLL, 16'($urandom_range(0, 65535)));
                  done++;
               end
               default: send_request(CMD_UNUSED, 16'($urandom_range(0, 65535)));
            endcase
         end
      end
   endtask

   initial begin
      reset                 <= 1'b1;
      req_chan.valid        <= 1'b0;
      req_chan.cmd          <= CMD_SAMPLE;
      req_chan.sample_value <= '0;
      csr_wr_en             <= 1'b0;
      csr_index             <= '0;
      csr_wdata             <= '0;
      thr_now[0]  = RST_THRESH_LEFT;
      thr_now[1]  = RST_THRESH_UP;
      thr_now[2]  = RST_THRESH_DOWN;
      thr_now[3]  = RST_THRESH_RIGHT;
      thr_now[4]  = RST_THRESH_ENTER;
      ticks_limit = RST_DEBOUNCE_TICKS;
      repeat (8) @(negedge clock);
      reset <= 1'b0;

      // Reset state: saturated counter holds under ticks, a fresh key is not
      // yet debounced
      send_request(CMD_POLL, 16'h0000);
      send_request(CMD_TICK, 16'h0000);
      send_request(CMD_TICK, 16'hFFFF);
      send_request(CMD_POLL, 16'h0000);
      send_request(CMD_SAMPLE, 16'd69);
      send_request(CMD_POLL, 16'hFFFF);
      send_request(CMD_UNUSED, 16'hFFFF);
      send_request(CMD_POLL, 16'h0000);

      // Walk every key at its threshold edges with a one-tick debounce
      load_config(RST_THRESH_LEFT, RST_THRESH_UP, RST_THRESH_DOWN,
                  RST_THRESH_RIGHT, RST_THRESH_ENTER, 16'd0);
      send_request(CMD_SAMPLE, 16'd0);
      send_request(CMD_TICK, 16'hFFFF);
      send_request(CMD_POLL, 16'h0000);
      send_request(CMD_SAMPLE, 16'd229);
      send_request(CMD_TICK, 16'h0000);
      send_request(CMD_POLL, 16'h0000);
      send_request(CMD_SAMPLE, 16'd409);
      send_request(CMD_TICK, 16'h0000);
      send_request(CMD_POLL, 16'h0000);
      send_request(CMD_SAMPLE, 16'd619);
      send_request(CMD_TICK, 16'h0000);
      send_request(CMD_POLL, 16'h0000);
      send_request(CMD_SAMPLE, 16'd879);
      send_request(CMD_TICK, 16'h0000);
      send_request(CMD_POLL, 16'h0000);
      send_request(CMD_SAMPLE, 16'hFFFF);
      send_request(CMD_TICK, 16'h0000);
      send_request(CMD_POLL, 16'h0000);
      send_request(CMD_SAMPLE, 16'd70);
      send_request(CMD_POLL, 16'h0000);

      // A limit at maximum can never be exceeded
      quiet = 1'b1;
      load_config(RST_THRESH_LEFT, RST_THRESH_UP, RST_THRESH_DOWN,
                  RST_THRESH_RIGHT, RST_THRESH_ENTER, 16'hFFFF);
      send_request(CMD_POLL, 16'h0000);
      quiet = 1'b0;

      // Random phases over a spread of settings
      load_config(RST_THRESH_LEFT, RST_THRESH_UP, RST_THRESH_DOWN,
                  RST_THRESH_RIGHT, RST_THRESH_ENTER, 16'($urandom_range(0, 5)));
      run_random_phase(ITEMS_PER_PHASE);
      load_sorted(16'($urandom_range(0, 10)));
      run_random_phase(ITEMS_PER_PHASE);
      load_config(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                  16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                  16'($urandom_range(0, 65535)), 16'($urandom_range(0, 3)));
      run_random_phase(ITEMS_PER_PHASE);
      load_config(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
      run_random_phase(ITEMS_PER_PHASE);
      load_config(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      run_random_phase(ITEMS_PER_PHASE);
      quiet = 1'b1;
      load_sorted(16'($urandom_range(1, 4)));
      run_random_phase(ITEMS_PER_PHASE);
      quiet = 1'b0;
      load_config(16'd1, 16'd2, 16'd3, 16'hFFFE, 16'hFFFF, 16'($urandom_range(0, 2)));
      run_random_phase(ITEMS_PER_PHASE);
      load_sorted(16'($urandom_range(0, 6)));
      run_random_phase(ITEMS_PER_PHASE);
      load_sorted(16'd65534);
      run_random_phase(ITEMS_PER_PHASE);

      // Let the last responses land, then give the verdict
      drain_requests();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (fail_count == 0 && pending_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

// File: files.f
rtl/core/akd_pkg.sv
rtl/core/akd_ifs.sv
rtl/core/akd_csr.sv
rtl/core/analog_keypad_debouncer_top.sv
dv/akd_checker.sv
dv/tb_top.sv
